// ----- rtl/ems_pkg.sv -----
// ems_pkg: shared types and constants of the edge magnitude stream block
// word structs for the pixel and result channels, control sideband, register codes
// no dependencies
`default_nettype none

package ems_pkg;

    localparam int PIX_W      = 8;
    localparam int COLS_W     = 11;
    localparam int ROWS_W     = 13;
    localparam int ROW_CNT_W  = 12;
    localparam int WARM_W     = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int EDGE_W     = 12;
    localparam int RESP_W     = 12;
    localparam int MAG_W      = 11;
    localparam int SUM_W      = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 2'd2;

    localparam logic [ROWS_W-1:0] ROWS_MAX = 13'd4096;
    localparam logic [EDGE_W-1:0] EDGE_MAX = 12'hfff;

    typedef struct packed {
        logic             action;
        logic [PIX_W-1:0] pixel;
    } ems_in_t;

    typedef struct packed {
        logic [EDGE_W-1:0] edge_value;
        logic              frame_last;
        logic [EDGE_W-1:0] frame_min;
        logic [EDGE_W-1:0] frame_max;
    } ems_out_t;

    typedef struct packed {
        logic emit;
        logic last;
        logic c_first;
        logic c_last;
        logic r_first;
        logic r_last;
        logic mode;
    } ems_ctl_t;

    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } ems_col_t;

    typedef struct packed {
        logic signed [RESP_W-1:0] v;
        logic signed [RESP_W-1:0] h;
        logic signed [RESP_W-1:0] rd;
        logic signed [RESP_W-1:0] ld;
    } ems_resp_t;

endpackage

`default_nettype wire

// ----- rtl/ems_ram.sv -----
// ems_ram: generic single-port ram, read-first, registered read data
// no dependencies
`default_nettype none

module ems_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wr_data;
            end
            rd_data_reg <= mem_reg[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/ems_line_cell.sv -----
// ems_line_cell: one line delay cell, delays the pixel stream by one image row
// carries a sideband word alongside; depends on ems_pkg and ems_ram
`default_nettype none

module ems_line_cell #(
    parameter int MAX_COLS = 1024,
    parameter int SIDE_W   = 8
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [ems_pkg::COLS_W-1:0]   cols,
    input  wire logic                         restart,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [ems_pkg::PIX_W-1:0]    in_pix,
    input  wire logic [SIDE_W-1:0]            in_side,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic      [ems_pkg::PIX_W-1:0]    out_pix,
    output logic      [ems_pkg::PIX_W-1:0]    out_dly,
    output logic      [SIDE_W-1:0]            out_side
);

    localparam int PW   = $clog2(MAX_COLS);
    localparam int CMPW = (PW > ems_pkg::COLS_W) ? PW : ems_pkg::COLS_W;

    logic                      valid_reg, valid_next;
    logic [PW-1:0]             ptr_reg, ptr_next;
    logic [ems_pkg::PIX_W-1:0] pix_reg, pix_next;
    logic [SIDE_W-1:0]         side_reg, side_next;
    logic                      stage_en;
    logic                      take;
    logic                      ptr_wrap;

    assign stage_en = !valid_reg || out_ready;
    assign take     = stage_en && in_valid;
    assign in_ready = stage_en;
    assign ptr_wrap = (CMPW'(ptr_reg) == CMPW'(cols - ems_pkg::COLS_W'(1)));

    always_comb
    begin
        valid_next = stage_en ? in_valid : valid_reg;
        ptr_next   = ptr_reg;
        if (restart)
        begin
            ptr_next = '0;
        end
        else if (take)
        begin
            ptr_next = ptr_wrap ? '0 : ptr_reg + PW'(1);
        end
        pix_next  = take ? in_pix : pix_reg;
        side_next = take ? in_side : side_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            ptr_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg  <= pix_next;
        side_reg <= side_next;
    end

    ems_ram #(
        .WIDTH (ems_pkg::PIX_W),
        .DEPTH (MAX_COLS)
    ) u_ram (
        .clk     (clk),
        .en      (take),
        .we      (take),
        .addr    (ptr_reg),
        .wr_data (in_pix),
        .rd_data (out_dly)
    );

    assign out_valid = valid_reg;
    assign out_pix   = pix_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

// ----- rtl/ems_edge.sv -----
// ems_edge: 3x3 window with border replication and the four kernel responses
// two pipeline stages; depends on ems_pkg
`default_nettype none

module ems_edge (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire ems_pkg::ems_col_t  in_col,
    input  wire ems_pkg::ems_ctl_t  in_ctl,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output ems_pkg::ems_resp_t      out_resp,
    output ems_pkg::ems_ctl_t       out_ctl
);

    function automatic ems_pkg::ems_col_t clamp_rows(ems_pkg::ems_col_t c, logic r_first,
                                                     logic r_last);
        ems_pkg::ems_col_t o;
        o = c;
        if (r_first)
        begin
            o.top = c.mid;
        end
        if (r_last)
        begin
            o.bot = c.mid;
        end
        return o;
    endfunction

    function automatic logic signed [ems_pkg::RESP_W-1:0] ext(logic [ems_pkg::PIX_W-1:0] p);
        return signed'({{(ems_pkg::RESP_W - ems_pkg::PIX_W){1'b0}}, p});
    endfunction

    ems_pkg::ems_col_t  colb_reg, colb_next;
    ems_pkg::ems_col_t  colc_reg, colc_next;
    ems_pkg::ems_col_t  left_reg, left_next;
    ems_pkg::ems_col_t  center_reg, center_next;
    ems_pkg::ems_col_t  right_reg, right_next;
    ems_pkg::ems_ctl_t  wctl_reg, wctl_next;
    logic               wv_reg, wv_next;
    ems_pkg::ems_resp_t resp_reg, resp_next;
    ems_pkg::ems_ctl_t  rctl_reg, rctl_next;
    logic               rv_reg, rv_next;

    logic               en_a, en_b, take_a, take_b;
    ems_pkg::ems_col_t  left_raw, right_raw;
    ems_pkg::ems_resp_t sob, rob;

    logic signed [ems_pkg::RESP_W-1:0] p00, p01, p02, p10, p11, p12, p20, p21, p22;

    assign en_b     = !rv_reg || out_ready;
    assign en_a     = !wv_reg || en_b;
    assign in_ready = en_a;
    assign take_a   = en_a && in_valid;
    assign take_b   = en_b && wv_reg;

    // column c+1 clamps to c at the right border, c-1 to c at the left border
    assign right_raw = in_ctl.c_last ? colb_reg : in_col;
    assign left_raw  = in_ctl.c_first ? colb_reg : colc_reg;

    always_comb
    begin
        colb_next   = take_a ? in_col : colb_reg;
        colc_next   = take_a ? colb_reg : colc_reg;
        left_next   = take_a ? clamp_rows(left_raw, in_ctl.r_first, in_ctl.r_last) : left_reg;
        center_next = take_a ? clamp_rows(colb_reg, in_ctl.r_first, in_ctl.r_last)
                             : center_reg;
        right_next  = take_a ? clamp_rows(right_raw, in_ctl.r_first, in_ctl.r_last)
                             : right_reg;
        wctl_next   = take_a ? in_ctl : wctl_reg;
        wv_next     = en_a ? in_valid : wv_reg;
    end

    assign p00 = ext(left_reg.top);
    assign p01 = ext(center_reg.top);
    assign p02 = ext(right_reg.top);
    assign p10 = ext(left_reg.mid);
    assign p11 = ext(center_reg.mid);
    assign p12 = ext(right_reg.mid);
    assign p20 = ext(left_reg.bot);
    assign p21 = ext(center_reg.bot);
    assign p22 = ext(right_reg.bot);

    always_comb
    begin
        sob.v  = p00 + (p01 <<< 1) + p02 - p20 - (p21 <<< 1) - p22;
        sob.h  = p00 + (p10 <<< 1) + p20 - p02 - (p12 <<< 1) - p22;
        sob.rd = (p00 <<< 1) + p01 + p10 - p12 - p21 - (p22 <<< 1);
        sob.ld = p01 + (p02 <<< 1) - p10 + p12 - (p20 <<< 1) - p21;
        // 2x2 block at (r,c), (r,c+1), (r+1,c), (r+1,c+1)
        rob.v  = p11 + p12 - p21 - p22;
        rob.h  = p11 - p12 + p21 - p22;
        rob.rd = p11 - p12 - p21 + p22;
        rob.ld = p12 + p21 - p11 - p22;
    end

    always_comb
    begin
        resp_next = resp_reg;
        if (take_b)
        begin
            resp_next = wctl_reg.mode ? sob : rob;
        end
        rctl_next = take_b ? wctl_reg : rctl_reg;
        rv_next   = en_b ? wv_reg : rv_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wv_reg <= 1'b0;
            rv_reg <= 1'b0;
        end
        else
        begin
            wv_reg <= wv_next;
            rv_reg <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        colb_reg   <= colb_next;
        colc_reg   <= colc_next;
        left_reg   <= left_next;
        center_reg <= center_next;
        right_reg  <= right_next;
        wctl_reg   <= wctl_next;
        resp_reg   <= resp_next;
        rctl_reg   <= rctl_next;
    end

    assign out_valid = rv_reg;
    assign out_resp  = resp_reg;
    assign out_ctl   = rctl_reg;

endmodule

`default_nettype wire

// ----- rtl/edge_magnitude_stream_top.sv -----
// edge_magnitude_stream_top: streaming Roberts or Sobel edge magnitude with frame min/max
// raster counters, config registers, output register; uses ems_pkg, ems_line_cell, ems_edge
//
// Usage:
//   in_word carries one pixel (action 0) or a drain word (action 1) in raster order;
//   a word is taken when in_valid is high and in_stall is low.
//   After the last pixel of a frame the host sends num_cols + 1 drain words.
//   The result for raster position k belongs to input word k + num_cols + 1 and
//   leaves on out_word from the output register (out_valid high, taken when
//   out_stall is low). Words that close no position give no result.
//   The last result of a frame has frame_last set and carries frame_min/frame_max.
//   Throughput: one word per cycle while out_stall is low; two line cells each
//   delay the stream by one row through a single-port ram of MAX_COLS entries,
//   then a window stage, a kernel stage and the output register follow.
//   When out_stall holds a result, words keep entering until every stage is
//   full, then in_stall rises.
//   Config words (cfg_valid, cfg_ready always high) must be written only while idle
//   (not enforced by the block); a num_cols or num_rows write restarts the frame.
//   Reset: mode Roberts, num_cols min(1024, MAX_COLS), num_rows 4096, pipeline empty.
`default_nettype none

module edge_magnitude_stream_top #(
    parameter int MAX_COLS = 1024
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire ems_pkg::ems_in_t                   in_word,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output ems_pkg::ems_out_t                       out_word,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [ems_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ems_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CTL_W  = $bits(ems_pkg::ems_ctl_t);
    localparam int SIDE_B = CTL_W + ems_pkg::PIX_W;

    localparam logic [ems_pkg::COLS_W-1:0] COLS_CAP =
        (MAX_COLS > 2047) ? 11'd2047 : ems_pkg::COLS_W'(MAX_COLS);
    localparam logic [ems_pkg::COLS_W-1:0] COLS_RST =
        (MAX_COLS < 1024) ? ems_pkg::COLS_W'(MAX_COLS) : 11'd1024;

    logic                          mode_reg, mode_next;
    logic [ems_pkg::COLS_W-1:0]    cols_reg, cols_next;
    logic [ems_pkg::ROWS_W-1:0]    rows_reg, rows_next;
    logic [ems_pkg::WARM_W-1:0]    warm_reg, warm_next;
    logic [ems_pkg::COLS_W-1:0]    col_reg, col_next;
    logic [ems_pkg::ROW_CNT_W-1:0] row_reg, row_next;
    logic [ems_pkg::EDGE_W-1:0]    run_min_reg, run_min_next;
    logic [ems_pkg::EDGE_W-1:0]    run_max_reg, run_max_next;
    logic                          out_valid_reg, out_valid_next;
    ems_pkg::ems_out_t             out_word_reg, out_word_next;

    logic                          cols_wr, geo_wr;
    logic [ems_pkg::COLS_W-1:0]    cfg_cols_raw, cfg_cols_v;
    logic [ems_pkg::ROWS_W-1:0]    cfg_rows_raw, cfg_rows_v;

    logic                          a_ready, accept;
    ems_pkg::ems_ctl_t             front_ctl;
    logic [ems_pkg::PIX_W-1:0]     px;

    logic                          a_valid, b_ready;
    logic [ems_pkg::PIX_W-1:0]     a_pix, a_dly;
    logic [CTL_W-1:0]              a_side;
    logic                          b_valid, e_ready;
    logic [ems_pkg::PIX_W-1:0]     b_pix, b_dly;
    logic [SIDE_B-1:0]             b_side;
    ems_pkg::ems_ctl_t             b_ctl;
    ems_pkg::ems_col_t             b_col;

    logic                          e_valid;
    ems_pkg::ems_resp_t            e_resp;
    ems_pkg::ems_ctl_t             e_ctl;

    logic                          out_ready_int, load;
    logic [ems_pkg::MAG_W-1:0]     mag_v, mag_h, mag_rd, mag_ld;
    logic [ems_pkg::SUM_W-1:0]     mag_sum;
    logic [ems_pkg::EDGE_W-1:0]    edge_sat, new_min, new_max;

    function automatic logic [ems_pkg::MAG_W-1:0] mag(logic signed [ems_pkg::RESP_W-1:0] x);
        return x[ems_pkg::RESP_W-1] ? ems_pkg::MAG_W'(-x) : ems_pkg::MAG_W'(x);
    endfunction

    // configuration
    assign cfg_ready    = 1'b1;
    assign cfg_cols_raw = cfg_data[ems_pkg::COLS_W-1:0];
    assign cfg_rows_raw = cfg_data[ems_pkg::ROWS_W-1:0];
    assign cfg_cols_v   = (cfg_cols_raw == '0) ? ems_pkg::COLS_W'(1)
                        : (cfg_cols_raw > COLS_CAP) ? COLS_CAP : cfg_cols_raw;
    assign cfg_rows_v   = (cfg_rows_raw == '0) ? ems_pkg::ROWS_W'(1)
                        : (cfg_rows_raw > ems_pkg::ROWS_MAX) ? ems_pkg::ROWS_MAX
                        : cfg_rows_raw;

    always_comb
    begin
        mode_next = mode_reg;
        cols_next = cols_reg;
        rows_next = rows_reg;
        cols_wr   = 1'b0;
        geo_wr    = 1'b0;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                ems_pkg::CFG_MODE:
                begin
                    mode_next = cfg_data[0];
                end
                ems_pkg::CFG_NUM_COLS:
                begin
                    cols_next = cfg_cols_v;
                    cols_wr   = 1'b1;
                    geo_wr    = 1'b1;
                end
                ems_pkg::CFG_NUM_ROWS:
                begin
                    rows_next = cfg_rows_v;
                    geo_wr    = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // raster position of the next result
    assign accept   = in_valid && a_ready;
    assign in_stall = !a_ready;
    assign px       = in_word.action ? '0 : in_word.pixel;

    always_comb
    begin
        front_ctl.emit    = (warm_reg == (ems_pkg::WARM_W'(cols_reg) + ems_pkg::WARM_W'(1)));
        front_ctl.c_first = (col_reg == '0);
        front_ctl.c_last  = (col_reg == cols_reg - ems_pkg::COLS_W'(1));
        front_ctl.r_first = (row_reg == '0);
        front_ctl.r_last  = (ems_pkg::ROWS_W'(row_reg) == rows_reg - ems_pkg::ROWS_W'(1));
        front_ctl.last    = front_ctl.emit && front_ctl.c_last && front_ctl.r_last;
        front_ctl.mode    = mode_reg;
    end

    always_comb
    begin
        warm_next = warm_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        if (geo_wr)
        begin
            warm_next = '0;
            col_next  = '0;
            row_next  = '0;
        end
        else if (accept)
        begin
            if (!front_ctl.emit)
            begin
                warm_next = warm_reg + ems_pkg::WARM_W'(1);
            end
            else if (front_ctl.last)
            begin
                warm_next = '0;
                col_next  = '0;
                row_next  = '0;
            end
            else if (front_ctl.c_last)
            begin
                col_next = '0;
                row_next = row_reg + ems_pkg::ROW_CNT_W'(1);
            end
            else
            begin
                col_next = col_reg + ems_pkg::COLS_W'(1);
            end
        end
    end

    // two line cells: rows r+1, r and r-1 of the column entering the window
    ems_line_cell #(
        .MAX_COLS (MAX_COLS),
        .SIDE_W   (CTL_W)
    ) u_cell_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .cols      (cols_reg),
        .restart   (cols_wr),
        .in_valid  (in_valid),
        .in_ready  (a_ready),
        .in_pix    (px),
        .in_side   (front_ctl),
        .out_valid (a_valid),
        .out_ready (b_ready),
        .out_pix   (a_pix),
        .out_dly   (a_dly),
        .out_side  (a_side)
    );

    ems_line_cell #(
        .MAX_COLS (MAX_COLS),
        .SIDE_W   (SIDE_B)
    ) u_cell_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .cols      (cols_reg),
        .restart   (cols_wr),
        .in_valid  (a_valid),
        .in_ready  (b_ready),
        .in_pix    (a_dly),
        .in_side   ({a_side, a_pix}),
        .out_valid (b_valid),
        .out_ready (e_ready),
        .out_pix   (b_pix),
        .out_dly   (b_dly),
        .out_side  (b_side)
    );

    assign b_ctl     = b_side[SIDE_B-1:ems_pkg::PIX_W];
    assign b_col.top = b_dly;
    assign b_col.mid = b_pix;
    assign b_col.bot = b_side[ems_pkg::PIX_W-1:0];

    ems_edge u_edge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_valid),
        .in_ready  (e_ready),
        .in_col    (b_col),
        .in_ctl    (b_ctl),
        .out_valid (e_valid),
        .out_ready (out_ready_int),
        .out_resp  (e_resp),
        .out_ctl   (e_ctl)
    );

    // magnitude sum, frame min/max and output register
    assign out_ready_int = !out_valid_reg || !out_stall;
    assign load          = out_ready_int && e_valid && e_ctl.emit;

    assign mag_v   = mag(e_resp.v);
    assign mag_h   = mag(e_resp.h);
    assign mag_rd  = mag(e_resp.rd);
    assign mag_ld  = mag(e_resp.ld);
    assign mag_sum = ems_pkg::SUM_W'(mag_v) + ems_pkg::SUM_W'(mag_h)
                   + ems_pkg::SUM_W'(mag_rd) + ems_pkg::SUM_W'(mag_ld);
    assign edge_sat = (mag_sum > ems_pkg::SUM_W'(ems_pkg::EDGE_MAX)) ? ems_pkg::EDGE_MAX
                    : mag_sum[ems_pkg::EDGE_W-1:0];
    assign new_min  = (edge_sat < run_min_reg) ? edge_sat : run_min_reg;
    assign new_max  = (edge_sat > run_max_reg) ? edge_sat : run_max_reg;

    always_comb
    begin
        out_valid_next = out_ready_int ? (e_valid && e_ctl.emit) : out_valid_reg;
        out_word_next  = out_word_reg;
        run_min_next   = run_min_reg;
        run_max_next   = run_max_reg;
        if (load)
        begin
            out_word_next.edge_value = edge_sat;
            out_word_next.frame_last = e_ctl.last;
            out_word_next.frame_min  = e_ctl.last ? new_min : '0;
            out_word_next.frame_max  = e_ctl.last ? new_max : '0;
            run_min_next = e_ctl.last ? ems_pkg::EDGE_MAX : new_min;
            run_max_next = e_ctl.last ? '0 : new_max;
        end
        if (geo_wr)
        begin
            run_min_next = ems_pkg::EDGE_MAX;
            run_max_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            cols_reg      <= COLS_RST;
            rows_reg      <= ems_pkg::ROWS_MAX;
            warm_reg      <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            run_min_reg   <= ems_pkg::EDGE_MAX;
            run_max_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            cols_reg      <= cols_next;
            rows_reg      <= rows_next;
            warm_reg      <= warm_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            run_min_reg   <= run_min_next;
            run_max_reg   <= run_max_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

`default_nettype wire

// ----- bench/edge_stream_checker.sv -----
// edge_stream_checker: result checker for edge_magnitude_stream_top
// follows the config, pixel and result channels, predicts every result word and compares it
// uses ems_pkg
module edge_stream_checker
    import ems_pkg::*;
#(
    parameter int MAX_COLS = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  ems_in_t               in_word,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  ems_out_t              out_word,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    expect_depth
);

    localparam int RING_LEN   = 2 * MAX_COLS + 3;
    localparam int ROWS_LIMIT = int'(ROWS_MAX);
    localparam int EDGE_LIMIT = int'(EDGE_MAX);

    logic [PIX_W-1:0] pix_ring [RING_LEN];
    ems_out_t         pending_results [$];
    logic             mode_q;
    int               cols_q;
    int               rows_q;
    int               col_pos;
    int               row_pos;
    int               item_cnt;
    int               low_q;
    int               high_q;
    int               result_cnt;
    int               n;
    int               v;
    int               grad;
    logic             at_end;
    ems_out_t         want;
    ems_out_t         got;

    task automatic report(input string what);
        $display("edge check: %s", what);
        fail_count++;
    endtask

    task automatic frame_restart();
        col_pos  = 0;
        row_pos  = 0;
        item_cnt = 0;
        low_q    = EDGE_LIMIT;
        high_q   = 0;
    endtask

    function automatic int mag(input int x);
        return (x < 0) ? -x : x;
    endfunction

    // border replication: row and column clamped into the frame
    function automatic int pix_at(input int r, input int c);
        int rr;
        int cc;
        rr = (r < 0) ? 0 : r;
        rr = (rr > rows_q - 1) ? rows_q - 1 : rr;
        cc = (c < 0) ? 0 : c;
        cc = (cc > cols_q - 1) ? cols_q - 1 : cc;
        return int'(pix_ring[(rr * cols_q + cc) % RING_LEN]);
    endfunction

    function automatic int grad_at(input int r, input int c);
        int p00;
        int p01;
        int p02;
        int p10;
        int p11;
        int p12;
        int p20;
        int p21;
        int p22;
        int gv;
        int gh;
        int gr;
        int gl;
        if (mode_q)
        begin
            p00 = pix_at(r - 1, c - 1);
            p01 = pix_at(r - 1, c);
            p02 = pix_at(r - 1, c + 1);
            p10 = pix_at(r, c - 1);
            p12 = pix_at(r, c + 1);
            p20 = pix_at(r + 1, c - 1);
            p21 = pix_at(r + 1, c);
            p22 = pix_at(r + 1, c + 1);
            gv  = p00 + 2 * p01 + p02 - p20 - 2 * p21 - p22;
            gh  = p00 + 2 * p10 + p20 - p02 - 2 * p12 - p22;
            gr  = 2 * p00 + p01 + p10 - p12 - p21 - 2 * p22;
            gl  = p01 + 2 * p02 - p10 + p12 - 2 * p20 - p21;
        end
        else
        begin
            p11 = pix_at(r, c);
            p12 = pix_at(r, c + 1);
            p21 = pix_at(r + 1, c);
            p22 = pix_at(r + 1, c + 1);
            gv  = p11 + p12 - p21 - p22;
            gh  = p11 - p12 + p21 - p22;
            gr  = p11 - p12 - p21 + p22;
            gl  = -p11 + p12 + p21 - p22;
        end
        return mag(gv) + mag(gh) + mag(gr) + mag(gl);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RING_LEN; i++)
                pix_ring[i] = '0;
            pending_results.delete();
            mode_q       = 1'b0;
            cols_q       = (MAX_COLS < 1024) ? MAX_COLS : 1024;
            rows_q       = ROWS_LIMIT;
            frame_restart();
            fail_count   = 0;
            result_cnt   = 0;
            expect_depth <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = out_word;
                if (pending_results.size() == 0)
                    report($sformatf("result word %0d with nothing expected", result_cnt));
                else
                begin
                    want = pending_results.pop_front();
                    if (got.edge_value !== want.edge_value || got.frame_last !== want.frame_last
                        || got.frame_min !== want.frame_min
                        || got.frame_max !== want.frame_max)
                        report($sformatf(
                            "word %0d got edge %0d last %0b min %0d max %0d, want %0d %0b %0d %0d",
                            result_cnt, got.edge_value, got.frame_last, got.frame_min,
                            got.frame_max, want.edge_value, want.frame_last, want.frame_min,
                            want.frame_max));
                end
                result_cnt++;
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MODE:
                        mode_q = cfg_data[0];
                    CFG_NUM_COLS:
                    begin
                        v      = int'(cfg_data[COLS_W-1:0]);
                        cols_q = (v == 0) ? 1 : ((v > MAX_COLS) ? MAX_COLS : v);
                        frame_restart();
                    end
                    CFG_NUM_ROWS:
                    begin
                        v      = int'(cfg_data[ROWS_W-1:0]);
                        rows_q = (v == 0) ? 1 : ((v > ROWS_LIMIT) ? ROWS_LIMIT : v);
                        frame_restart();
                    end
                    default:
                        ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                n = item_cnt;
                pix_ring[n % RING_LEN] = in_word.action ? '0 : in_word.pixel;
                item_cnt = n + 1;
                if (n >= cols_q + 1)
                begin
                    grad = grad_at(row_pos, col_pos);
                    if (grad > EDGE_LIMIT)
                        grad = EDGE_LIMIT;
                    if (grad < low_q)
                        low_q = grad;
                    if (grad > high_q)
                        high_q = grad;
                    at_end = (row_pos + 1 >= rows_q) && (col_pos + 1 >= cols_q);
                    want.edge_value = EDGE_W'(grad);
                    want.frame_last = at_end;
                    want.frame_min  = at_end ? EDGE_W'(low_q) : '0;
                    want.frame_max  = at_end ? EDGE_W'(high_q) : '0;
                    pending_results.push_back(want);
                    if (at_end)
                        frame_restart();
                    else if (col_pos + 1 >= cols_q)
                    begin
                        col_pos = 0;
                        row_pos++;
                    end
                    else
                        col_pos++;
                end
            end

            expect_depth <= pending_results.size();
        end
    end

endmodule

// ----- bench/tb_edge_magnitude_stream_top.sv -----
// tb_edge_magnitude_stream_top: stimulus and verdict for edge_magnitude_stream_top
// drives pixel, drain and config words under random idling; checking sits in edge_stream_checker
// uses ems_pkg, edge_magnitude_stream_top, edge_stream_checker
module tb_edge_magnitude_stream_top;
    import ems_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int MAX_COLS      = 1024;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int RANDOM_WORDS  = 110;
    localparam int NO_CAP        = 1 << 30;
    localparam int MODE_PAD_W    = CFG_DATA_W - 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    ems_in_t               in_word   = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_stall;
    logic                  out_valid;
    ems_out_t              out_word;
    logic                  cfg_ready;
    int                    fail_count;
    int                    expect_depth;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int words_sent    = 0;
    int cycle_cnt     = 0;
    int hold_left     = 0;
    bit hold_ask      = 1'b0;
    bit hold_seen     = 1'b0;
    bit cur_mode      = 1'b0;

    edge_magnitude_stream_top #(
        .MAX_COLS (MAX_COLS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    edge_stream_checker #(
        .MAX_COLS (MAX_COLS)
    ) u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_word      (in_word),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_word     (out_word),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .expect_depth (expect_depth)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("edge_magnitude_stream_top regression: fail");
            $finish;
        end
    end

    // result side: random stall, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_ask != hold_seen)
        begin
            hold_seen <= hold_ask;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_word(input logic act, input logic [PIX_W-1:0] px);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        in_word.action <= act;
        in_word.pixel  <= px;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val,
                             input bit more);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (!more)
            cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do
        begin
            while (expect_depth != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
        while (expect_depth != 0);
    endtask

    task automatic configure(input bit m, input logic [CFG_DATA_W-1:0] cols_raw,
                             input logic [CFG_DATA_W-1:0] rows_raw);
        settle();
        cur_mode = m;
        write_reg(CFG_MODE, {MODE_PAD_W'($urandom), m}, 1'b1);
        write_reg(CFG_NUM_COLS, cols_raw, 1'b1);
        write_reg(CFG_NUM_ROWS, rows_raw, 1'b0);
    endtask

    // pixels of one frame then its drain words; noise swaps word kinds, cap cuts the frame short
    task automatic send_frame(input int cols, input int rows, input int noise_pct, input bit flip,
                              input int cap);
        int               pix_words;
        int               total;
        int               split;
        int               style;
        logic             act;
        logic [PIX_W-1:0] px;
        pix_words = cols * rows;
        total     = pix_words + cols + 1;
        if (total > cap)
            total = cap;
        split = $urandom_range(total - 1);
        style = $urandom_range(2);
        for (int i = 0; i < total; i++)
        begin
            if (flip && i == split)
            begin
                settle();
                cur_mode = ~cur_mode;
                write_reg(CFG_MODE, {MODE_PAD_W'($urandom), cur_mode}, 1'b0);
            end
            if (i < pix_words)
                act = ($urandom_range(99) < noise_pct);
            else
                act = ($urandom_range(99) >= noise_pct);
            case (style)
                0:       px = PIX_W'($urandom);
                1:       px = $urandom_range(1) ? {PIX_W{1'b1}} : '0;
                default: px = PIX_W'($urandom_range(120, 135));
            endcase
            send_word(act, px);
        end
    endtask

    initial
    begin
        int base;
        int cols;
        int rows;
        cols = 1;
        rows = 1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // sobel on a 3x2 checkerboard, a drain inside the pixels, a pixel among the drains
        configure(1'b1, 3, 2);
        for (int i = 0; i < 6; i++)
            send_word(i == 3, (i % 2 == 0 || i == 3) ? {PIX_W{1'b1}} : '0);
        for (int i = 0; i < 4; i++)
            send_word(i != 2, 8'h5a);

        // unused register index, then zero geometry reading as a single pixel
        settle();
        write_reg(CFG_SPARE, '1, 1'b0);
        configure(1'b0, '0, '0);
        send_word(1'b0, {PIX_W{1'b1}});
        send_word(1'b1, '0);
        send_word(1'b0, 8'h81);

        // roberts on a 2x3 checkerboard
        configure(1'b0, 2, 3);
        for (int i = 0; i < 6; i++)
            send_word(1'b0, ((i + i / 2) % 2) ? {PIX_W{1'b1}} : '0);
        for (int i = 0; i < 3; i++)
            send_word(1'b1, PIX_W'($urandom));

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 12 : ((phase == 1) ? 82 : 0);
            stall_pct     = (phase == 0) ? 82 : ((phase == 1) ? 12 : 0);

            if (phase != 1)
            begin
                configure($urandom_range(1), 8, 6);
                hold_ask = ~hold_ask;
                send_frame(8, 6, 0, 1'b0, NO_CAP);
            end

            if (phase == 2)
            begin
                // oversized writes clamp to the largest geometry
                configure($urandom_range(1), 13'h7ff, 13'h1fff);
                send_frame(MAX_COLS, int'(ROWS_MAX), 5, 1'b0, 24);
                configure(1'b0, 1, ROWS_MAX);
                send_frame(1, int'(ROWS_MAX), 5, 1'b1, 80);
            end

            base = words_sent;
            while (words_sent - base < RANDOM_WORDS)
            begin
                if (words_sent == base || $urandom_range(2) != 0)
                begin
                    cols = ($urandom_range(7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
                    rows = $urandom_range(1, 6);
                    configure($urandom_range(1),
                              CFG_DATA_W'(cols) | (CFG_DATA_W'($urandom_range(3)) << COLS_W),
                              CFG_DATA_W'(rows));
                end
                send_frame(cols, rows, ($urandom_range(4) == 0) ? 10 : 0,
                           $urandom_range(4) == 0,
                           ($urandom_range(9) == 0) ? $urandom_range(1, 20) : NO_CAP);
            end
        end

        settle();
        if (fail_count == 0 && expect_depth == 0)
            $display("edge_magnitude_stream_top regression: pass");
        else
            $display("edge_magnitude_stream_top regression: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/ems_pkg.sv
rtl/ems_ram.sv
rtl/ems_line_cell.sv
rtl/ems_edge.sv
rtl/edge_magnitude_stream_top.sv
bench/edge_stream_checker.sv
bench/tb_edge_magnitude_stream_top.sv
